// ===== hw/rtl/lrgd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrgd_pkg: shared types and constants
// Constants, opcodes, FSM states and controller/datapath command structs.
// ----------------------------------------------------------------------------
package lrgd_pkg;

    localparam int DEF_NUM_SAMPLES  = 4;
    localparam int DEF_NUM_FEATURES = 3;

    localparam logic [15:0] RST_LEARNING_RATE  = 16'd655;
    localparam logic [19:0] RST_MAX_ITERATIONS = 20'd100000;
    localparam logic [31:0] RST_COST_THRESHOLD = 32'd1;

    localparam logic [1:0] OP_LOAD_FEATURE = 2'd0;
    localparam logic [1:0] OP_LOAD_TARGET  = 2'd1;
    localparam logic [1:0] OP_TRAIN        = 2'd2;

    localparam logic [1:0] REG_LEARNING_RATE  = 2'd0;
    localparam logic [1:0] REG_MAX_ITERATIONS = 2'd1;
    localparam logic [1:0] REG_COST_THRESHOLD = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PRED,
        ST_PRED_END,
        ST_COST,
        ST_CHECK,
        ST_GRAD,
        ST_STEP,
        ST_STEP_END,
        ST_EMIT
    } lrgd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // zero weights, iteration count
        logic pred_mac;   // accumulate one x*w term (sample s_idx, weight w_idx)
        logic pred_wr;    // store saturated prediction for s_idx
        logic cost_acc;   // accumulate error square for s_idx
        logic cost_fin;   // divide and saturate cost
        logic grad_mac;   // accumulate one e*x term for weight w_idx, sample s_idx
        logic step_mul;   // step weight w_idx (stage 1: rate multiply)
        logic step_wr;    // stage 2: divide and write weight
        logic iter_inc;
        logic acc_clr;
    } lrgd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done_ok;    // cost at/under threshold or limit reached
    } lrgd_sts_t;

endpackage

// ===== hw/rtl/lrgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrgd_ctrl: training sequencer
// Walks samples and weights through predict, cost, gradient and step phases.
// ----------------------------------------------------------------------------
module lrgd_ctrl #(
    parameter int NUM_SAMPLES  = lrgd_pkg::DEF_NUM_SAMPLES,
    parameter int NUM_FEATURES = lrgd_pkg::DEF_NUM_FEATURES,
    localparam int NW = NUM_FEATURES + 1,
    localparam int SW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1,
    localparam int WW = $clog2(NW)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    output logic                 busy,
    output lrgd_pkg::lrgd_cmd_t  cmd,
    input  lrgd_pkg::lrgd_sts_t  sts,
    output logic [SW-1:0]        s_idx,
    output logic [WW-1:0]        w_idx,
    output logic                 emit_valid,
    input  logic                 emit_ready
);
    import lrgd_pkg::*;

    lrgd_state_t   state_reg, state_next;
    logic [SW-1:0] s_reg, s_next;
    logic [WW-1:0] w_reg, w_next;

    localparam logic [SW-1:0] S_LAST = SW'(NUM_SAMPLES - 1);
    localparam logic [WW-1:0] W_LAST = WW'(NW - 1);

    assign s_idx = s_reg;
    assign w_idx = w_reg;
    assign busy  = (state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            s_reg     <= '0;
            w_reg     <= '0;
        end else begin
            state_reg <= state_next;
            s_reg     <= s_next;
            w_reg     <= w_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_next     = s_reg;
        w_next     = w_reg;
        cmd        = '0;
        emit_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.clear   = 1'b1;
                cmd.acc_clr = 1'b1;
                s_next      = '0;
                w_next      = '0;
                state_next  = ST_PRED;
            end
            ST_PRED: begin
                cmd.pred_mac = 1'b1;
                if (w_reg == W_LAST) begin
                    w_next     = '0;
                    state_next = ST_PRED_END;
                end else begin
                    w_next = w_reg + 1'b1;
                end
            end
            ST_PRED_END: begin
                cmd.pred_wr = 1'b1;
                cmd.acc_clr = 1'b1;
                if (s_reg == S_LAST) begin
                    s_next     = '0;
                    state_next = ST_COST;
                end else begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_PRED;
                end
            end
            ST_COST: begin
                cmd.cost_acc = 1'b1;
                if (s_reg == S_LAST) begin
                    s_next     = '0;
                    state_next = ST_CHECK;
                end else begin
                    s_next = s_reg + 1'b1;
                end
            end
            ST_CHECK: begin
                cmd.cost_fin = 1'b1;
                state_next   = ST_STEP_END;
            end
            ST_STEP_END: begin
                // cost register now valid
                cmd.acc_clr = 1'b1;
                w_next      = '0;
                s_next      = '0;
                state_next  = sts.done_ok ? ST_EMIT : ST_GRAD;
            end
            ST_GRAD: begin
                cmd.grad_mac = 1'b1;
                if (s_reg == S_LAST) begin
                    s_next     = '0;
                    state_next = ST_STEP;
                end else begin
                    s_next = s_reg + 1'b1;
                end
            end
            ST_STEP: begin
                // two-stage weight update, then next weight
                if (s_reg == '0) begin
                    cmd.step_mul = 1'b1;
                    s_next       = SW'(1);
                end else begin
                    cmd.step_wr = 1'b1;
                    cmd.acc_clr = 1'b1;
                    s_next      = '0;
                    if (w_reg == W_LAST) begin
                        w_next       = '0;
                        cmd.iter_inc = 1'b1;
                        state_next   = ST_PRED;
                    end else begin
                        w_next     = w_reg + 1'b1;
                        state_next = ST_GRAD;
                    end
                end
            end
            ST_EMIT: begin
                emit_valid = 1'b1;
                if (emit_ready) begin
                    if (w_reg == W_LAST) begin
                        w_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        w_next = w_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/lrgd_dp.sv =====
// ----------------------------------------------------------------------------
// lrgd_dp: datapath
// Sample stores, weights, one shared MAC accumulator, cost and step units.
// ----------------------------------------------------------------------------
module lrgd_dp #(
    parameter int NUM_SAMPLES  = lrgd_pkg::DEF_NUM_SAMPLES,
    parameter int NUM_FEATURES = lrgd_pkg::DEF_NUM_FEATURES,
    localparam int NW = NUM_FEATURES + 1,
    localparam int SW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1,
    localparam int WW = $clog2(NW)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ld_feat,
    input  logic                 ld_targ,
    input  logic [5:0]           ld_sample,
    input  logic [3:0]           ld_feature,
    input  logic signed [31:0]   ld_value,
    input  logic [15:0]          learning_rate,
    input  logic [19:0]          max_iterations,
    input  logic [31:0]          cost_threshold,
    input  lrgd_pkg::lrgd_cmd_t  cmd,
    output lrgd_pkg::lrgd_sts_t  sts,
    input  logic [SW-1:0]        s_idx,
    input  logic [WW-1:0]        w_idx,
    output logic signed [31:0]   weight_out,
    output logic [19:0]          iter_out,
    output logic [31:0]          cost_out
);
    import lrgd_pkg::*;

    localparam int NF = NUM_SAMPLES * NUM_FEATURES;
    localparam int FW = (NF > 1) ? $clog2(NF) : 1;

    logic signed [31:0] feat_mem [NF];
    logic signed [31:0] targ_mem [NUM_SAMPLES];
    logic signed [31:0] pred_reg [NUM_SAMPLES];
    logic signed [31:0] w_reg    [NW];
    logic signed [63:0] acc_reg;
    logic [63:0]        cacc_reg;
    logic [31:0]        cost_reg;
    logic [19:0]        iter_reg;
    logic signed [63:0] prod_reg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)       return 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648) return 32'sh80000000;
        else                           return x[31:0];
    endfunction

    // feature x(s, j), column 0 is 1.0
    logic signed [31:0] x_sel;
    logic [FW-1:0]      f_addr;
    logic [WW-1:0]      w_m1;
    always_comb begin
        w_m1   = w_idx - 1'b1;
        f_addr = FW'(32'(s_idx) * NUM_FEATURES + 32'(w_m1));
        x_sel  = (w_idx == '0) ? 32'sh00010000 : feat_mem[f_addr];
    end

    logic signed [32:0] err;
    assign err = 33'(pred_reg[s_idx]) - 33'(targ_mem[s_idx]);

    logic signed [63:0] pmul;
    logic signed [65:0] gmul;
    logic [65:0]        esq;
    logic [32:0]        emag;
    always_comb begin
        pmul = 64'(x_sel) * 64'(w_reg[w_idx]);
        gmul = 66'(err) * 66'(x_sel);
        emag = err[32] ? 33'(-err) : 33'(err);
        esq  = 66'(emag) * 66'(emag);
    end

    // rate step: floor(g*alpha/2^16), then divide by N truncating
    logic signed [80:0] rmul;
    logic signed [63:0] step;
    logic signed [64:0] wnew;
    assign rmul = 81'(acc_reg) * $signed({65'd0, learning_rate});
    assign step = prod_reg / NUM_SAMPLES;
    assign wnew = 65'(w_reg[w_idx]) - 65'(step);

    logic [63:0] cdiv;
    assign cdiv = cacc_reg / (2 * NUM_SAMPLES);

    always_ff @(posedge aclk) begin
        if (ld_feat) begin
            feat_mem[FW'(32'(ld_sample) * NUM_FEATURES + 32'(ld_feature) - 1)] <= ld_value;
        end
        if (ld_targ) begin
            targ_mem[SW'(ld_sample)] <= ld_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NW; i++) w_reg[i] <= '0;
            for (int i = 0; i < NUM_SAMPLES; i++) pred_reg[i] <= '0;
            iter_reg <= '0;
            acc_reg  <= '0;
            cacc_reg <= '0;
            cost_reg <= '0;
        end else begin
            if (cmd.clear) begin
                for (int i = 0; i < NW; i++) w_reg[i] <= '0;
                iter_reg <= '0;
                cacc_reg <= '0;
            end
            if (cmd.acc_clr) acc_reg <= '0;
            if (cmd.pred_mac) acc_reg <= acc_reg + (pmul >>> 16);
            if (cmd.grad_mac) acc_reg <= acc_reg + 64'(gmul >>> 16);
            if (cmd.pred_wr) pred_reg[s_idx] <= sat32(acc_reg);
            if (cmd.cost_acc) cacc_reg <= cacc_reg + 64'(esq >> 16);
            if (cmd.cost_fin) begin
                cost_reg <= (cdiv > 64'hFFFFFFFF) ? 32'hFFFFFFFF : cdiv[31:0];
                cacc_reg <= '0;
            end
            if (cmd.step_mul) prod_reg <= 64'(rmul >>> 16);
            if (cmd.step_wr) w_reg[w_idx] <= sat32(wnew[63:0]);
            if (cmd.iter_inc) iter_reg <= iter_reg + 1'b1;
        end
    end

    assign sts.done_ok = (iter_reg >= max_iterations) || (cost_reg <= cost_threshold);
    assign weight_out  = w_reg[w_idx];
    assign iter_out    = iter_reg;
    assign cost_out    = cost_reg;

endmodule

// ===== hw/rtl/linear_regression_gradient_descent_unit.sv =====
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent_unit: batch linear regression trainer
// Loads Q16.16 samples, trains weights by batch descent, reports weights.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         content
//  s_axis    in   s_tvalid/tready   load feature, load target, train
//  m_axis    out  m_tvalid/tready   one item per weight, tlast on highest
//  apb       in   psel/penable      learning_rate, max_iterations, threshold
//
//  Load items never make the block busy. A train item holds the block busy
//  through every descent iteration and the weight emission; the single shared
//  multiply-accumulate serialises this work.
//  Reset (aresetn low, synchronous) restores register defaults, zeros weights.
//  Output stalls hold the sequencer in its emit state.
module linear_regression_gradient_descent_unit #(
    parameter int NUM_SAMPLES  = lrgd_pkg::DEF_NUM_SAMPLES,
    parameter int NUM_FEATURES = lrgd_pkg::DEF_NUM_FEATURES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tuser,   // op[1:0]
    input  logic [47:0] s_tdata,   // sample_index[5:0], feature_index[9:6], value[41:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // weight_index[3:0], weight_value[35:4],
                                   // iterations_done[55:36], final_cost[87:56]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lrgd_pkg::*;

    localparam int NW = NUM_FEATURES + 1;
    localparam int SW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int WW = $clog2(NW);

    logic [15:0] rate_reg;
    logic [19:0] maxit_reg;
    logic [31:0] thr_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= RST_LEARNING_RATE;
            maxit_reg <= RST_MAX_ITERATIONS;
            thr_reg   <= RST_COST_THRESHOLD;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LEARNING_RATE:  rate_reg  <= pwdata[15:0];
                REG_MAX_ITERATIONS: maxit_reg <= pwdata[19:0];
                REG_COST_THRESHOLD: thr_reg   <= pwdata;
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_LEARNING_RATE:  prdata = {16'd0, rate_reg};
            REG_MAX_ITERATIONS: prdata = {12'd0, maxit_reg};
            REG_COST_THRESHOLD: prdata = thr_reg;
            default:            prdata = '0;
        endcase
    end

    logic [1:0]  op;
    logic [5:0]  smp;
    logic [3:0]  fi;
    logic        busy, acc_in;
    assign op  = s_tuser[1:0];
    assign smp = s_tdata[5:0];
    assign fi  = s_tdata[9:6];
    assign s_tready = !busy;
    assign acc_in   = s_tvalid && s_tready;

    logic ld_feat, ld_targ, start;
    assign ld_feat = acc_in && op == OP_LOAD_FEATURE && 32'(smp) < NUM_SAMPLES
                     && fi != 4'd0 && 32'(fi) <= NUM_FEATURES;
    assign ld_targ = acc_in && op == OP_LOAD_TARGET && 32'(smp) < NUM_SAMPLES;
    assign start   = acc_in && op == OP_TRAIN;

    lrgd_cmd_t     cmd;
    lrgd_sts_t     sts;
    logic [SW-1:0] s_idx;
    logic [WW-1:0] w_idx;
    logic signed [31:0] wout;
    logic [19:0]   iter;
    logic [31:0]   cost;

    lrgd_ctrl #(.NUM_SAMPLES(NUM_SAMPLES), .NUM_FEATURES(NUM_FEATURES)) u_ctrl (
        .aclk, .aresetn, .start, .busy, .cmd, .sts, .s_idx, .w_idx,
        .emit_valid(m_tvalid), .emit_ready(m_tready)
    );

    lrgd_dp #(.NUM_SAMPLES(NUM_SAMPLES), .NUM_FEATURES(NUM_FEATURES)) u_dp (
        .aclk, .aresetn, .ld_feat, .ld_targ, .ld_sample(smp), .ld_feature(fi),
        .ld_value(s_tdata[41:10]), .learning_rate(rate_reg),
        .max_iterations(maxit_reg), .cost_threshold(thr_reg), .cmd, .sts,
        .s_idx, .w_idx, .weight_out(wout), .iter_out(iter), .cost_out(cost)
    );

    assign m_tdata = {cost, iter, wout, 4'(w_idx)};
    assign m_tlast = (w_idx == WW'(NW - 1));

endmodule

// ===== dv/linear_regression_gradient_descent_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent_unit_tb: self-checking bench
// Loads sample tables over the input stream, trains, and checks every reported
// weight, step count and cost against a fixed-point predictor of the trainer.
// ----------------------------------------------------------------------------
module linear_regression_gradient_descent_unit_tb;
    import lrgd_pkg::*;

    localparam int          NS        = DEF_NUM_SAMPLES;
    localparam int          NF        = DEF_NUM_FEATURES;
    localparam int          NW        = NF + 1;
    localparam logic [1:0]  OP_UNUSED = 2'd3;     // not decoded, ignored
    localparam int          IDLE_LIMIT = 200000;  // cycles with no handshake
    localparam int          DRAIN_WAIT = 40;      // settle time after last item

    // one reported weight
    typedef struct {
        logic [3:0]  widx;
        logic [31:0] wval;
        logic [19:0] iters;
        logic [31:0] cost;
        logic        last;
    } weight_rpt_t;

    // ------------------------------------------------------------------------
    // Trainer predictor and expected weight reports
    // ------------------------------------------------------------------------
    class lrgd_scoreboard;
        logic [15:0]  rate;
        logic [19:0]  iter_limit;
        logic [31:0]  threshold;
        int           feats [NS*NF];
        int           targets [NS];
        int           weights [NW];
        int           preds [NS];
        weight_rpt_t  pending_rpts [$];
        int           n_mismatch;
        int           n_checked;
        int           n_trains;
        int           max_steps;

        function new();
            rate = RST_LEARNING_RATE;
            iter_limit = RST_MAX_ITERATIONS;
            threshold = RST_COST_THRESHOLD;
            n_mismatch = 0;
            n_checked = 0;
            n_trains = 0;
            max_steps = 0;
        endfunction

        function int sat32(longint x);
            if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (x < -64'sd2147483648) return 32'sh80000000;
            return int'(x);
        endfunction

        function int xval(int s, int j);
            return (j == 0) ? 32'sd65536 : feats[s*NF + j - 1];
        endfunction

        function void predict();
            longint acc;
            for (int s = 0; s < NS; s++) begin
                acc = 0;
                for (int j = 0; j < NW; j++)
                    acc += (longint'(xval(s, j)) * longint'(weights[j])) >>> 16;
                preds[s] = sat32(acc);
            end
        endfunction

        function logic [31:0] half_mse();
            bit [63:0] acc, m;
            longint    e;
            acc = 0;
            for (int s = 0; s < NS; s++) begin
                e = longint'(preds[s]) - longint'(targets[s]);
                m = (e < 0) ? -e : e;
                acc += (m * m) >> 16;
            end
            acc = acc / (2 * NS);
            return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        endfunction

        function void descend();
            longint grad [NW];
            longint e, hi, prod;
            bit [63:0] lo;
            for (int i = 0; i < NW; i++) begin
                grad[i] = 0;
                for (int s = 0; s < NS; s++) begin
                    e = longint'(preds[s]) - longint'(targets[s]);
                    grad[i] += (e * longint'(xval(s, i))) >>> 16;
                end
            end
            for (int i = 0; i < NW; i++) begin
                hi = grad[i] >>> 16;
                lo = grad[i] & 64'hFFFF;
                prod = hi * longint'(rate) + longint'((lo * rate) >> 16);
                weights[i] = sat32(longint'(weights[i]) - prod / NS);
            end
        endfunction

        // note one accepted input item
        function void note_item(logic [1:0] op, logic [5:0] s, logic [3:0] f,
                                logic [31:0] v);
            logic [31:0] c;
            int          steps;
            weight_rpt_t r;
            case (op)
                OP_LOAD_FEATURE: begin
                    if (s < NS && f >= 1 && f <= NF) feats[s*NF + f - 1] = v;
                end
                OP_LOAD_TARGET: begin
                    if (s < NS) targets[s] = v;
                end
                OP_TRAIN: begin
                    foreach (weights[i]) weights[i] = 0;
                    steps = 0;
                    predict();
                    c = half_mse();
                    while (steps < iter_limit && c > threshold) begin
                        descend();
                        steps++;
                        predict();
                        c = half_mse();
                    end
                    for (int j = 0; j < NW; j++) begin
                        r.widx = 4'(j);
                        r.wval = weights[j];
                        r.iters = 20'(steps);
                        r.cost = c;
                        r.last = (j == NW - 1);
                        pending_rpts.push_back(r);
                    end
                    n_trains++;
                    if (steps > max_steps) max_steps = steps;
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, weight_rpt_t exp_r, weight_rpt_t got);
            n_mismatch++;
            if (n_mismatch <= 10) begin
                $display("%t MISMATCH %s: exp idx=%0d w=%h it=%0d cost=%h last=%b",
                         $realtime, what, exp_r.widx, exp_r.wval, exp_r.iters,
                         exp_r.cost, exp_r.last);
                $display("    got idx=%0d w=%h it=%0d cost=%h last=%b",
                         got.widx, got.wval, got.iters, got.cost, got.last);
            end
        endfunction

        function void check_rpt(weight_rpt_t got);
            weight_rpt_t exp_r;
            if (pending_rpts.size() == 0) begin
                exp_r = '{default: 'x};
                flag("unexpected item", exp_r, got);
                return;
            end
            exp_r = pending_rpts.pop_front();
            n_checked++;
            if (got.widx !== exp_r.widx)   flag("weight_index", exp_r, got);
            if (got.wval !== exp_r.wval)   flag("weight_value", exp_r, got);
            if (got.iters !== exp_r.iters) flag("iterations_done", exp_r, got);
            if (got.cost !== exp_r.cost)   flag("final_cost", exp_r, got);
            if (got.last !== exp_r.last)   flag("last", exp_r, got);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its inputs
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tuser = '0;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    linear_regression_gradient_descent_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 aclk = ~aclk;

    lrgd_scoreboard weights_sb = new();

    int         idle_cycles = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    logic [7:0] stall_pattern = 8'hFF;  // m_tready follows this, bit per cycle
    int         stall_phase = 0;

    // receiver back-pressure: rotating pattern, changed per test phase
    always @(negedge aclk) begin
        m_tready = stall_pattern[stall_phase];
        stall_phase = (stall_phase + 1) % 8;
    end

    // result monitor
    always @(posedge aclk) begin
        weight_rpt_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.widx  = m_tdata[3:0];
            got.wval  = m_tdata[35:4];
            got.iters = m_tdata[55:36];
            got.cost  = m_tdata[87:56];
            got.last  = m_tlast;
            weights_sb.check_rpt(got);
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
            $display("linear_regression_gradient_descent_unit_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // APB write: setup cycle then access cycle; block must be idle
    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_LEARNING_RATE:  weights_sb.rate = data[15:0];
            REG_MAX_ITERATIONS: weights_sb.iter_limit = data[19:0];
            REG_COST_THRESHOLD: weights_sb.threshold = data;
            default: ;
        endcase
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_config(logic [15:0] rate, logic [19:0] lim, logic [31:0] thr);
        reg_write(REG_LEARNING_RATE, {16'd0, rate});
        reg_write(REG_MAX_ITERATIONS, {12'd0, lim});
        reg_write(REG_COST_THRESHOLD, thr);
    endtask

    // one item on the input stream, with bursty gaps between groups
    task automatic send_item(logic [1:0] op, logic [5:0] s, logic [3:0] f,
                             logic [31:0] v);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tuser  = {6'd0, op};
        s_tdata  = {6'd0, v, f, s};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        weights_sb.note_item(op, s, f, v);
        items_sent++;
        burst_left--;
    endtask

    // hold the sender until every pending report is back, then settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (weights_sb.pending_rpts.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // rewrite the whole table, mostly small values so descent settles
    task automatic load_table(bit wide);
        logic [31:0] v;
        for (int s = 0; s < NS; s++) begin
            for (int f = 1; f <= NF; f++) begin
                v = wide ? $urandom() : $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
                send_item(OP_LOAD_FEATURE, 6'(s), 4'(f), v);
            end
            v = wide ? $urandom() : $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
            send_item(OP_LOAD_TARGET, 6'(s), 4'd0, v);
        end
    endtask

    // random phase: well-formed load-then-train runs plus noise
    task automatic random_phase(int n_items);
        int stop_at;
        int pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                load_table($urandom_range(0, 7) == 0);
                send_item(OP_TRAIN, 6'($urandom()), 4'($urandom()), $urandom());
            end else if (pick < 8) begin
                // partial reload, then train
                repeat ($urandom_range(1, 5))
                    send_item(2'($urandom_range(0, 1)), 6'($urandom_range(0, NS - 1)),
                              4'($urandom_range(1, NF)),
                              $urandom_range(0, 32'h7FFFF) - 32'h3FFFF);
                send_item(OP_TRAIN, 6'($urandom()), 4'($urandom()), $urandom());
            end else begin
                // noise: any field value, any op including unused
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom()), 6'($urandom()), 4'($urandom()),
                              $urandom());
            end
            if ($urandom_range(0, 15) == 0) drain();  // mid-phase full stop
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // defaults would allow very long runs; tighten first
        set_config(16'd4000, 20'd30, 32'd0);

        // directed: fill every table entry with stepped values
        for (int s = 0; s < NS; s++)
            for (int f = 1; f <= NF; f++)
                send_item(OP_LOAD_FEATURE, 6'(s), 4'(f), 32'h0001_0000 * (s + f));
        for (int s = 0; s < NS; s++)
            send_item(OP_LOAD_TARGET, 6'(s), 4'd0, 32'h0002_8000 * (s + 1));
        // loads that fall outside the table, and the unused op
        send_item(OP_LOAD_FEATURE, 6'd63, 4'd15, 32'hFFFF_FFFF);
        send_item(OP_LOAD_FEATURE, 6'd1, 4'd0, 32'h1234_5678);
        send_item(OP_LOAD_TARGET, 6'd4, 4'd0, 32'h8000_0000);
        send_item(OP_UNUSED, 6'd2, 4'd2, 32'h7FFF_FFFF);
        send_item(OP_TRAIN, 6'd0, 4'd0, 32'd0);
        drain();

        // iteration limit of zero, and threshold already met
        set_config(16'd4000, 20'd0, 32'd0);
        send_item(OP_TRAIN, 6'd0, 4'd0, 32'd0);
        drain();
        set_config(16'd4000, 20'd50, 32'hFFFF_FFFF);
        send_item(OP_TRAIN, 6'd0, 4'd0, 32'd0);
        drain();

        // saturating values
        set_config(16'hFFFF, 20'd5, 32'd0);
        send_item(OP_LOAD_FEATURE, 6'd0, 4'd1, 32'h7FFF_FFFF);
        send_item(OP_LOAD_FEATURE, 6'd3, 4'd3, 32'h8000_0000);
        send_item(OP_LOAD_TARGET, 6'd1, 4'd0, 32'h8000_0000);
        send_item(OP_LOAD_TARGET, 6'd2, 4'd0, 32'h7FFF_FFFF);
        send_item(OP_TRAIN, 6'd0, 4'd0, 32'd0);
        drain();

        // random phases, each with its own settings and stall pattern
        stall_pattern = 8'hFF;
        set_config(16'hFFFF, 20'd20, 32'd0);
        random_phase(80);

        stall_pattern = 8'($urandom_range(1, 255));
        set_config(16'd0, 20'd40, 32'd100);
        random_phase(80);

        stall_pattern = 8'b0000_0001;
        set_config(16'($urandom()), 20'hFFFFF, 32'hFFFF_FFFF);
        random_phase(50);

        stall_pattern = 8'($urandom_range(1, 255)) | 8'h10;
        set_config(16'($urandom_range(200, 8000)), 20'($urandom_range(1, 60)),
                   $urandom_range(0, 5000));
        random_phase(100);

        if (weights_sb.pending_rpts.size() != 0) weights_sb.n_mismatch++;
        $display("run covered %0d input items, %0d training runs, %0d weights checked",
                 items_sent, weights_sb.n_trains, weights_sb.n_checked);
        $display("longest run took %0d descent steps, %0d mismatches",
                 weights_sb.max_steps, weights_sb.n_mismatch);
        if (weights_sb.n_mismatch == 0) begin
            $display("linear_regression_gradient_descent_unit_tb: clean");
        end else begin
            $display("linear_regression_gradient_descent_unit_tb: errors");
        end
        $finish;
    end

endmodule
